@@ sv/bfsa_pkg.sv @@
// ----------------------------------------------------------------------------
// bfsa_pkg
// Shared types and codes of the best-fit segment allocator.
// ----------------------------------------------------------------------------
package bfsa_pkg;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NO_MATCH = 2'd3
    } t_status;

    typedef struct packed {
        logic exact;
        logic better;
        logic match;
    } t_eval;

endpackage

@@ sv/bfsa_ram.sv @@
// ----------------------------------------------------------------------------
// bfsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ sv/bfsa_eval.sv @@
// ----------------------------------------------------------------------------
// bfsa_eval
// Shared compare unit: checks one table entry against the current command.
// ----------------------------------------------------------------------------
module bfsa_eval
    import bfsa_pkg::*;
#(
    parameter int OFFSET_WIDTH = 16,
    parameter int OWNER_WIDTH  = 8,
    parameter int CMP_WIDTH    = 16
) (
    input  logic                    i_used,
    input  logic [OFFSET_WIDTH-1:0] i_size,
    input  logic [OWNER_WIDTH-1:0]  i_owner,
    input  logic [CMP_WIDTH-1:0]    i_req,
    input  logic [OWNER_WIDTH-1:0]  i_cur_owner,
    input  logic                    i_found,
    input  logic [OFFSET_WIDTH-1:0] i_best_size,
    output t_eval                   o_eval
);

    logic [CMP_WIDTH-1:0] size_ext;

    assign size_ext      = CMP_WIDTH'(i_size);
    assign o_eval.exact  = !i_used && (size_ext == i_req);
    assign o_eval.better = !i_used && (size_ext > i_req) && (!i_found || i_size < i_best_size);
    assign o_eval.match  = i_used && (i_owner == i_cur_owner);

endmodule

@@ sv/best_fit_segment_allocator.sv @@
// ----------------------------------------------------------------------------
// best_fit_segment_allocator
// Address-ordered segment table with best-fit allocate and release by owner.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// command   in         start&!busy&!i_cfg_we  i_command, i_owner_id, i_request_size
// result    out        o_done (one cycle)     o_status, o_start_offset
// config    in         i_cfg_we               i_cfg_wdata (memory_size)
//
// An item scans the table with one read per cycle; a split then shifts the
// entries above the best fit up by one slot to insert the remainder. The
// table RAM read port sets the pace. Reset and each config write rebuild the
// first table entry in S_INIT, with busy high. The result shows for one
// cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module best_fit_segment_allocator
    import bfsa_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int OFFSET_WIDTH = 16,
    parameter int OWNER_WIDTH  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [7:0]  i_owner_id,
    input  logic [15:0] i_request_size,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [15:0] o_start_offset,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    localparam int AW  = $clog2(MAX_SEGMENTS);
    localparam int CW  = (OFFSET_WIDTH > 16) ? OFFSET_WIDTH : 16;
    localparam int EW  = 2 * OFFSET_WIDTH + OWNER_WIDTH + 1;
    localparam logic [CW-1:0] OFF_MASK = CW'((64'd1 << OFFSET_WIDTH) - 64'd1);
    localparam logic [AW:0] MAX_CNT = (AW + 1)'(MAX_SEGMENTS);

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_SHIFT = 6'b001000,
        S_WREM  = 6'b010000,
        S_WBEST = 6'b100000
    } t_state;

    t_state                  r_state, n_state;
    logic [15:0]             r_mem_size, n_mem_size;
    logic [AW:0]             r_count, n_count;
    logic [AW:0]             r_i, n_i;
    logic                    r_pv, n_pv;
    logic [AW-1:0]           r_pi, n_pi;
    logic [AW-1:0]           r_j, n_j;
    logic                    r_sv, n_sv;
    logic [AW-1:0]           r_sj, n_sj;
    logic                    r_cmd, n_cmd;
    logic [OWNER_WIDTH-1:0]  r_owner, n_owner;
    logic [CW-1:0]           r_req, n_req;
    logic                    r_found, n_found;
    logic                    r_hit, n_hit;
    logic [AW-1:0]           r_best, n_best;
    logic [OFFSET_WIDTH-1:0] r_best_size, n_best_size;
    logic [OFFSET_WIDTH-1:0] r_best_start, n_best_start;
    logic                    r_done, n_done;
    t_status                 r_status, n_status;
    logic [15:0]             r_offset, n_offset;

    logic                    we;
    logic [AW-1:0]           waddr, raddr;
    logic [EW-1:0]           wdata, rdata;
    logic [OFFSET_WIDTH-1:0] e_start, e_size, tot;
    logic [OWNER_WIDTH-1:0]  e_owner;
    logic                    e_used;
    logic [CW-1:0]           mem_ext;
    t_eval                   ev;

    assign e_start = rdata[EW-1 -: OFFSET_WIDTH];
    assign e_size  = rdata[OWNER_WIDTH+OFFSET_WIDTH -: OFFSET_WIDTH];
    assign e_owner = rdata[OWNER_WIDTH:1];
    assign e_used  = rdata[0];
    assign mem_ext = CW'(r_mem_size);
    assign tot     = (mem_ext > OFF_MASK) ? OFF_MASK[OFFSET_WIDTH-1:0]
                                          : mem_ext[OFFSET_WIDTH-1:0];

    bfsa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    bfsa_eval #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .OWNER_WIDTH  (OWNER_WIDTH),
        .CMP_WIDTH    (CW)
    ) u_eval (
        .i_used      (e_used),
        .i_size      (e_size),
        .i_owner     (e_owner),
        .i_req       (r_req),
        .i_cur_owner (r_owner),
        .i_found     (r_found),
        .i_best_size (r_best_size),
        .o_eval      (ev)
    );

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_start_offset = r_offset;

    always_comb begin
        n_state      = r_state;
        n_mem_size   = r_mem_size;
        n_count      = r_count;
        n_i          = r_i;
        n_pv         = 1'b0;
        n_pi         = r_pi;
        n_j          = r_j;
        n_sv         = 1'b0;
        n_sj         = r_sj;
        n_cmd        = r_cmd;
        n_owner      = r_owner;
        n_req        = r_req;
        n_found      = r_found;
        n_hit        = r_hit;
        n_best       = r_best;
        n_best_size  = r_best_size;
        n_best_start = r_best_start;
        n_done       = 1'b0;
        n_status     = r_status;
        n_offset     = r_offset;
        we           = 1'b0;
        waddr        = r_pi;
        wdata        = rdata;
        raddr        = r_i[AW-1:0];

        case (r_state)
            S_INIT: begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = {{OFFSET_WIDTH{1'b0}}, tot, {OWNER_WIDTH{1'b0}}, 1'b0};
                n_count = (tot == '0) ? '0 : (AW + 1)'(1);
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_cfg_we) begin
                    n_mem_size = i_cfg_wdata;
                    n_state    = S_INIT;
                end else if (start) begin
                    n_cmd   = i_command;
                    n_owner = OWNER_WIDTH'(i_owner_id);
                    n_req   = CW'(i_request_size);
                    n_i     = '0;
                    n_found = 1'b0;
                    n_hit   = 1'b0;
                    if (i_command == CMD_ALLOC && i_request_size == 16'd0) begin
                        n_done   = 1'b1;
                        n_status = ST_NO_FIT;
                        n_offset = '0;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_i < r_count) begin
                    n_pv = 1'b1;
                    n_pi = r_i[AW-1:0];
                    n_i  = r_i + 1'b1;
                end
                if (r_pv) begin
                    if (r_cmd == CMD_RELEASE) begin
                        if (ev.match) begin
                            we    = 1'b1;
                            wdata = {e_start, e_size, {OWNER_WIDTH{1'b0}}, 1'b0};
                            n_hit = 1'b1;
                        end
                    end else if (ev.exact) begin
                        we       = 1'b1;
                        wdata    = {e_start, e_size, r_owner, 1'b1};
                        n_done   = 1'b1;
                        n_status = ST_OK;
                        n_offset = 16'(CW'(e_start));
                        n_pv     = 1'b0;
                        n_state  = S_IDLE;
                    end else if (ev.better) begin
                        n_found      = 1'b1;
                        n_best       = r_pi;
                        n_best_size  = e_size;
                        n_best_start = e_start;
                    end
                end
                if (!(r_i < r_count) && !r_pv) begin
                    if (r_cmd == CMD_RELEASE) begin
                        n_done   = 1'b1;
                        n_status = r_hit ? ST_OK : ST_NO_MATCH;
                        n_offset = '0;
                        n_state  = S_IDLE;
                    end else if (!r_found) begin
                        n_done   = 1'b1;
                        n_status = ST_NO_FIT;
                        n_offset = '0;
                        n_state  = S_IDLE;
                    end else if (r_count >= MAX_CNT) begin
                        n_done   = 1'b1;
                        n_status = ST_FULL;
                        n_offset = '0;
                        n_state  = S_IDLE;
                    end else begin
                        n_j     = AW'(r_count - 1'b1);
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                raddr = r_j;
                if (r_sv) begin
                    we    = 1'b1;
                    waddr = r_sj + 1'b1;
                    wdata = rdata;
                end
                if (r_j > r_best) begin
                    n_sv = 1'b1;
                    n_sj = r_j;
                    n_j  = r_j - 1'b1;
                end else if (!r_sv) begin
                    n_state = S_WREM;
                end
            end
            S_WREM: begin
                we      = 1'b1;
                waddr   = r_best + 1'b1;
                wdata   = {r_best_start + r_req[OFFSET_WIDTH-1:0],
                           r_best_size - r_req[OFFSET_WIDTH-1:0],
                           {OWNER_WIDTH{1'b0}}, 1'b0};
                n_state = S_WBEST;
            end
            S_WBEST: begin
                we       = 1'b1;
                waddr    = r_best;
                wdata    = {r_best_start, r_req[OFFSET_WIDTH-1:0], r_owner, 1'b1};
                n_count  = r_count + 1'b1;
                n_done   = 1'b1;
                n_status = ST_OK;
                n_offset = 16'(CW'(r_best_start));
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase

        if (i_cfg_we) begin
            n_mem_size = i_cfg_wdata;
            n_done     = 1'b0;
            n_state    = S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_mem_size <= 16'hFFFF;
            r_count    <= '0;
            r_pv       <= 1'b0;
            r_sv       <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mem_size <= n_mem_size;
            r_count    <= n_count;
            r_pv       <= n_pv;
            r_sv       <= n_sv;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i          <= n_i;
        r_pi         <= n_pi;
        r_j          <= n_j;
        r_sj         <= n_sj;
        r_cmd        <= n_cmd;
        r_owner      <= n_owner;
        r_req        <= n_req;
        r_found      <= n_found;
        r_hit        <= n_hit;
        r_best       <= n_best;
        r_best_size  <= n_best_size;
        r_best_start <= n_best_start;
        r_status     <= n_status;
        r_offset     <= n_offset;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("segment count exceeds table depth");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == S_IDLE))
        else $error("result strobe while sequencer active");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_cfg_we) |=> (busy || o_done))
        else $error("accepted command neither processed nor answered");

    a_split_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WBEST && !i_cfg_we) |=> (r_count == $past(r_count) + 1'b1))
        else $error("split did not add a segment");

endmodule
